FILE: design/vcbp_pkg.sv
// Shared types and constants for the variable-length code bit packer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vcbp_pkg;

  localparam int NUM_SYMS         = 6;
  localparam int SYM_W            = 3;
  localparam int CODE_REG_W       = 12;
  localparam int LEN_W            = 4;
  localparam int CODE_W           = 8;
  localparam int BYTE_W           = 8;
  localparam int MAX_CODE_LEN_DEF = 8;
  localparam int APB_DATA_W       = 32;
  localparam int ADDR_W           = 5;
  localparam int REG_IDX_W        = ADDR_W - 2;

  // Queue between the lookup front end and the packing back end.
  // The depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CODE_REG_W-1:0] CODE_RESET [NUM_SYMS] = '{
    12'h506, 12'h631, 12'h409, 12'h8E3, 12'h855, 12'h71F
  };

  // One looked-up code word: clamped length and the code masked to it.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } code_entry_t;

endpackage

`default_nettype wire

FILE: design/vcbp_front.sv
// Front end: code registers on the APB port, symbol lookup and classification.
// Depends on vcbp_pkg; feeds code entries into vcbp_queue.
`timescale 1ns / 1ps
`default_nettype none

module vcbp_front import vcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  input  wire logic                  in_valid,
  input  wire logic [SYM_W-1:0]      in_symbol,
  output logic                       in_stall,
  input  wire logic                  q_full,
  output logic                       push,
  output code_entry_t                push_entry
);

  logic [CODE_REG_W-1:0] code_r [NUM_SYMS];
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  reg_ok;
  logic                  sym_ok;
  logic [CODE_REG_W-1:0] sel_reg;
  logic [LEN_W-1:0]      raw_len;
  logic [LEN_W-1:0]      len;
  logic [CODE_W-1:0]     len_mask;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_ok  = reg_idx < REG_IDX_W'(NUM_SYMS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SYMS; i++) begin
        code_r[i] <= CODE_RESET[i];
      end
    end else if (psel && penable && pwrite && reg_ok) begin
      code_r[reg_idx] <= pwdata[CODE_REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_ok) begin
      prdata = APB_DATA_W'(code_r[reg_idx]);
    end
  end

  // Symbols outside the table and zero-length codes leave no trace downstream.
  assign sym_ok  = in_symbol < SYM_W'(NUM_SYMS);
  assign sel_reg = sym_ok ? code_r[in_symbol] : '0;
  assign raw_len = sel_reg[CODE_REG_W-1:CODE_W];
  assign len     = (raw_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : raw_len;

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      len_mask[i] = LEN_W'(i) < len;
    end
  end

  assign in_stall        = q_full;
  assign push            = in_valid && !q_full && sym_ok && (len != '0);
  assign push_entry.len  = len;
  assign push_entry.code = sel_reg[CODE_W-1:0] & len_mask;

endmodule

`default_nettype wire

FILE: design/vcbp_queue.sv
// Short FIFO of code entries between the front end and the back end.
// Depends on vcbp_pkg for the entry type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module vcbp_queue import vcbp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire code_entry_t push_entry,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output code_entry_t head
);

  code_entry_t       entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full       = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: design/vcbp_back.sv
// Back end: appends code bits to the pending buffer and packs full bytes.
// Depends on vcbp_pkg; drains vcbp_queue and owns the output register.
`timescale 1ns / 1ps
`default_nettype none

module vcbp_back import vcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire code_entry_t       q_head,
  output logic                   pop,
  output logic                   out_valid,
  output logic      [BYTE_W-1:0] out_packed_byte,
  input  wire logic              out_stall
);

  localparam int PEND_W = BYTE_W + MAX_CODE_LEN;
  localparam int CNT_W  = $clog2(PEND_W + 1);

  logic [BYTE_W-1:0] pend_r;
  logic [BYTE_W-1:0] pend_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PEND_W-1:0] cat;
  logic [PEND_W-1:0] shifted;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  rem;
  logic [BYTE_W-1:0] rem_mask;
  logic              emit;
  logic              out_free;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;

  // The pending buffer never holds more than one byte between items, so the
  // appended word is at most a byte plus one code long.
  assign cat     = (PEND_W'(pend_r) << q_head.len) | PEND_W'(q_head.code);
  assign total   = cnt_r + CNT_W'(q_head.len);
  assign emit    = total > CNT_W'(BYTE_W);
  assign rem     = total - CNT_W'(BYTE_W);
  assign shifted = cat >> rem;

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      rem_mask[i] = CNT_W'(i) < rem;
    end
    if (emit) begin
      pend_nxt = cat[BYTE_W-1:0] & rem_mask;
      cnt_nxt  = rem;
    end else begin
      pend_nxt = cat[BYTE_W-1:0];
      cnt_nxt  = total;
    end
  end

  // An entry that makes no byte may pass even while the output is blocked.
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = q_valid && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pend_r <= pend_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte_r <= shifted[BYTE_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_byte = out_byte_r;

endmodule

`default_nettype wire

FILE: design/vlc_code_bit_packer.sv
// Variable-length code bit packer, top level.
// A byte enters the output register when the back end pops the queue entry of the
// symbol that completes it. Throughput: one symbol per cycle while in_stall is
// low, set by the combinational append and pack in the back end; a four-entry
// queue absorbs stalls. Reset (synchronous, active low) restores the code table
// and empties the pending bit buffer, the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module vlc_code_bit_packer import vcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  input  wire logic [SYM_W-1:0]      in_symbol,
  output logic                       in_stall,
  output logic                       out_valid,
  output logic      [BYTE_W-1:0]     out_packed_byte,
  input  wire logic                  out_stall
);

  logic        q_full;
  logic        push;
  code_entry_t push_entry;
  logic        pop;
  logic        q_valid;
  code_entry_t q_head;

  assign pready = 1'b1;

  vcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .in_valid   (in_valid),
    .in_symbol  (in_symbol),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  vcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  vcbp_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_packed_byte (out_packed_byte),
    .out_stall       (out_stall)
  );

endmodule

`default_nettype wire

FILE: design/vcbp_checker.sv
// Port-level checks for vlc_code_bit_packer, attached by the bind below.
// Depends on vcbp_pkg for the port widths.
`timescale 1ns / 1ps
`default_nettype none

module vcbp_checker import vcbp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic [BYTE_W-1:0] out_packed_byte,
  input wire logic              out_stall
);

  // A byte held back by the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_packed_byte))
    else $error("stalled output transaction changed or vanished");

  // Reset leaves the input open and the output empty.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !in_stall && !out_valid)
    else $error("queue or output not empty after reset");

  // The queue can only fill up while a finished byte is blocked at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule

bind vlc_code_bit_packer vcbp_checker u_vcbp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_packed_byte (out_packed_byte),
  .out_stall       (out_stall)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for vlc_code_bit_packer: a directed table, then random symbol
// streams over several code tables, checked against typed bytes or an in-bench predictor.
// Depends on vcbp_pkg and the vlc_code_bit_packer top level only.
`timescale 1ns / 1ps

module tb_top;
  import vcbp_pkg::*;

  localparam int MAX_LEN        = MAX_CODE_LEN_DEF;
  localparam int SETTLE_CYCLES  = 8;    // queue plus output register, with margin
  localparam int QUIET_LIMIT    = 4000; // cycles with no transaction on any port
  localparam int ITEMS_PER_STEP = 200;  // coded symbols per code table setting
  localparam int NUM_SETTINGS   = 6;

  typedef enum logic {ROW_SYMBOL, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NO_BYTE, CHK_BYTE} row_check_t;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CODE_SYM0, REG_CODE_SYM1, REG_CODE_SYM2,
    REG_CODE_SYM3, REG_CODE_SYM4, REG_CODE_SYM5
  } code_reg_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [SYM_W-1:0]      sym;
    code_reg_t             reg_sel;
    logic [CODE_REG_W-1:0] value;
    row_check_t            check;
    logic [BYTE_W-1:0]     exp_byte;
  } stim_row_t;

  localparam int NUM_ROWS = 28;
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    // Reset code table: 00110, 110001, 1001, 11100011, 01010101, 0011111.
    '{ROW_SYMBOL, 3'd0, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd1, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h36},
    '{ROW_SYMBOL, 3'd3, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h3C},
    '{ROW_SYMBOL, 3'd6, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd7, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd4, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h6A},
    '{ROW_SYMBOL, 3'd2, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd5, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'hB2},
    // Zero length with code bits set, clamped lengths, one-bit code, code above length.
    '{ROW_WRITE,  3'd0, REG_CODE_SYM0, 12'h0FF, CHK_MODEL,   8'h00},
    '{ROW_WRITE,  3'd0, REG_CODE_SYM1, 12'hFFF, CHK_MODEL,   8'h00},
    '{ROW_WRITE,  3'd0, REG_CODE_SYM2, 12'h1FE, CHK_MODEL,   8'h00},
    '{ROW_WRITE,  3'd0, REG_CODE_SYM3, 12'h800, CHK_MODEL,   8'h00},
    '{ROW_WRITE,  3'd0, REG_CODE_SYM4, 12'hF00, CHK_MODEL,   8'h00},
    '{ROW_WRITE,  3'd0, REG_CODE_SYM5, 12'h9AB, CHK_MODEL,   8'h00},
    '{ROW_SYMBOL, 3'd0, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd2, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    // Exactly eight bits pending must not yet produce a byte.
    '{ROW_SYMBOL, 3'd2, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd1, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h7C},
    '{ROW_SYMBOL, 3'd2, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'hFF},
    '{ROW_SYMBOL, 3'd1, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h7F},
    '{ROW_SYMBOL, 3'd3, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h80},
    '{ROW_SYMBOL, 3'd4, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h00},
    '{ROW_SYMBOL, 3'd5, REG_CODE_SYM0, 12'h000, CHK_BYTE,    8'h55},
    '{ROW_SYMBOL, 3'd6, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd7, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd0, REG_CODE_SYM0, 12'h000, CHK_NO_BYTE, 8'h00},
    '{ROW_SYMBOL, 3'd3, REG_CODE_SYM0, 12'h000, CHK_MODEL,   8'h00},
    '{ROW_SYMBOL, 3'd5, REG_CODE_SYM0, 12'h000, CHK_MODEL,   8'h00}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic [SYM_W-1:0]      in_symbol;
  logic                  in_stall;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_packed_byte;
  logic                  out_stall;

  vlc_code_bit_packer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_symbol       (in_symbol),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_packed_byte (out_packed_byte),
    .out_stall       (out_stall)
  );

  // Predictor state: the code table as written, and the pending bit buffer.
  logic [CODE_REG_W-1:0] code_table [NUM_SYMS];
  logic [15:0]           pend_bits;
  logic [4:0]            pend_count;
  logic [BYTE_W-1:0]     expected_bytes [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int symbols_sent;
  int blank_symbols;
  int bytes_checked;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Appends the code word of one symbol and returns 1 when a byte is completed.
  function automatic bit append_code(input logic [SYM_W-1:0] sym,
                                     output logic [BYTE_W-1:0] packed_val);
    logic [LEN_W-1:0]  len;
    logic [15:0]       mask;
    logic [CODE_W-1:0] code;
    logic [31:0]       shifted;
    packed_val = '0;
    if (sym >= NUM_SYMS) return 1'b0;
    len = code_table[sym][CODE_REG_W-1:CODE_W];
    if (len > MAX_LEN) len = LEN_W'(MAX_LEN);
    mask = (16'd1 << len) - 16'd1;
    code = code_table[sym][CODE_W-1:0] & mask[CODE_W-1:0];
    shifted = ({16'd0, pend_bits} << len) | {24'd0, code};
    pend_bits = shifted[15:0];
    pend_count = pend_count + 5'(len);
    if (pend_count <= BYTE_W) return 1'b0;
    shifted = {16'd0, pend_bits} >> (pend_count - 5'(BYTE_W));
    packed_val = shifted[BYTE_W-1:0];
    pend_count = pend_count - 5'(BYTE_W);
    pend_bits = pend_bits & ((16'd1 << pend_count) - 16'd1);
    return 1'b1;
  endfunction

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input row_check_t check,
                             input logic [BYTE_W-1:0] typed_byte);
    logic [BYTE_W-1:0] predicted;
    bit                completes;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    in_symbol = sym;
    do @(posedge clk); while (in_stall !== 1'b0);
    completes = append_code(sym, predicted);
    symbols_sent++;
    if (sym >= NUM_SYMS) blank_symbols++;
    case (check)
      CHK_MODEL: if (completes) expected_bytes.push_back(predicted);
      CHK_BYTE:  expected_bytes.push_back(typed_byte);
      default:   ;
    endcase
  endtask

  // Stops sending and waits until every expected byte has arrived, then lets
  // symbols that carry no byte clear the queue.
  task automatic drain_outputs();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code_reg(input code_reg_t idx, input logic [CODE_REG_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    code_table[idx] = value;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== APB_DATA_W'(value)) begin
      mismatch_count++;
      $display("%0t: readback of code register %0d: expected %h, actual %h",
               $time, idx, APB_DATA_W'(value), prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [CODE_REG_W-1:0] pick_code(input int setting, input int idx);
    case (setting)
      0:       return CODE_RESET[idx];
      1:       return {($urandom_range(1) != 0) ? 4'd8 : 4'd15, 8'($urandom)};
      2:       return {4'($urandom_range(3)), 8'($urandom)};
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // Receiver: stall decisions change only at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected byte: expected none, actual %h", $time, out_packed_byte);
      end else begin
        if (out_packed_byte !== expected_bytes[0]) begin
          mismatch_count++;
          $display("%0t: packed_byte mismatch: expected %h, actual %h",
                   $time, expected_bytes[0], out_packed_byte);
        end
        void'(expected_bytes.pop_front());
        bytes_checked++;
      end
    end
  end

  // Even the slowest legal run keeps making transactions, so a long quiet
  // stretch means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("vlc_code_bit_packer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         coded;
    stim_row_t  row;
    logic [2:0] sym;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_symbol      = '0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    symbols_sent   = 0;
    blank_symbols  = 0;
    bytes_checked  = 0;
    send_idle_pct  = 25;
    recv_stall_pct = 82;
    for (int i = 0; i < NUM_SYMS; i++) code_table[i] = CODE_RESET[i];
    pend_bits  = '0;
    pend_count = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = STIM_ROWS[r];
      if (row.kind == ROW_WRITE) begin
        drain_outputs();
        write_code_reg(row.reg_sel, row.value);
      end else begin
        send_symbol(row.sym, row.check, row.exp_byte);
      end
    end

    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      if (setting == 2) begin
        send_idle_pct  = 82;
        recv_stall_pct = 25;
      end else if (setting == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      drain_outputs();
      for (int i = 0; i < NUM_SYMS; i++) write_code_reg(code_reg_t'(i), pick_code(setting, i));
      coded = 0;
      while (coded < ITEMS_PER_STEP) begin
        if (coded == ITEMS_PER_STEP / 2) drain_outputs();
        if ($urandom_range(99) < 6) sym = 3'($urandom_range(7, 6));
        else                        sym = 3'($urandom_range(5, 0));
        send_symbol(sym, CHK_MODEL, 8'h00);
        if (sym < NUM_SYMS) coded++;
      end
    end

    drain_outputs();
    if (expected_bytes.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
    end
    $display("Sent %0d symbols (%0d with no code word) over %0d code table settings,",
             symbols_sent, blank_symbols, NUM_SETTINGS + 2);
    $display("checked %0d packed bytes under three sender and receiver stall mixes.",
             bytes_checked);
    if (mismatch_count == 0) begin
      $display("vlc_code_bit_packer verification clean");
    end else begin
      $display("vlc_code_bit_packer verification failed");
    end
    $finish;
  end

endmodule

FILE: vlc_code_bit_packer.f
design/vcbp_pkg.sv
design/vcbp_front.sv
design/vcbp_queue.sv
design/vcbp_back.sv
design/vlc_code_bit_packer.sv
design/vcbp_checker.sv
tb/tb_top.sv
